/* rtl/xxh32_stream_hasher_macros.svh */
// ----------------------------------------------------------------------------
// XXH32 stream hasher assertion macros
// Shorthand for clocked properties sampled on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef XXH32_STREAM_HASHER_MACROS_SVH
`define XXH32_STREAM_HASHER_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define XXH_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define XXH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent holds after the antecedent, delayed past the |=> implication.
`define XXH_ASSERT_NEXT2(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> ##1 (cons)) \
        else $error(msg);

`endif

/* rtl/xxh_pkg.sv */
// ----------------------------------------------------------------------------
// XXH32 stream hasher package
// Hash constants and the command and status types between controller and
// datapath.
// ----------------------------------------------------------------------------
package xxh_pkg;

    localparam logic [31:0] PRIME1 = 32'h9E3779B1;
    localparam logic [31:0] PRIME2 = 32'h85EBCA77;
    localparam logic [31:0] PRIME3 = 32'hC2B2AE3D;
    localparam logic [31:0] PRIME4 = 32'h27D4EB2F;
    localparam logic [31:0] PRIME5 = 32'h165667B1;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_WRITE,
        DP_RMUL,
        DP_RADD,
        DP_RMUL2,
        DP_FINIT,
        DP_FLANE,
        DP_WMUL,
        DP_WADD,
        DP_WMUL2,
        DP_BMUL,
        DP_BADD,
        DP_BMUL2,
        DP_AV1,
        DP_AV2,
        DP_AV3
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] lane;
    } t_dp_cmd;

    typedef struct packed {
        logic [4:0] fill;
        logic       stripe_full_next;
        logic       pend_done_next;
        logic       last;
        logic       long_msg;
    } t_dp_status;

endpackage

/* rtl/xxh_ctrl.sv */
// ----------------------------------------------------------------------------
// XXH32 stream hasher controller
// Sequences byte writes, stripe rounds, the finish steps and the result
// handshake; drives one datapath command per cycle.
// ----------------------------------------------------------------------------
module xxh_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  xxh_pkg::t_dp_status i_status,
    output xxh_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_WRITE = 16'h0002,
        S_RMUL  = 16'h0004,
        S_RADD  = 16'h0008,
        S_RMUL2 = 16'h0010,
        S_FINIT = 16'h0020,
        S_FLANE = 16'h0040,
        S_WMUL  = 16'h0080,
        S_WADD  = 16'h0100,
        S_WMUL2 = 16'h0200,
        S_BMUL  = 16'h0400,
        S_BADD  = 16'h0800,
        S_BMUL2 = 16'h1000,
        S_AV1   = 16'h2000,
        S_AV2   = 16'h4000,
        S_AV3   = 16'h8000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_lane, n_lane;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;

    // Picks the next tail step from the number of leftover stripe bytes.
    function automatic t_state tail_state(input logic [4:0] f);
        if (f >= 5'd4) begin
            return S_WMUL;
        end else if (f != 5'd0) begin
            return S_BMUL;
        end else begin
            return S_AV1;
        end
    endfunction

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_lane      = r_lane;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd.op    = xxh_pkg::DP_NOP;
        o_cmd.lane  = r_lane;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = xxh_pkg::DP_LOAD;
                    n_state  = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.op = xxh_pkg::DP_WRITE;
                if (i_status.stripe_full_next) begin
                    n_state = S_RMUL;
                    n_lane  = 2'd0;
                end else if (i_status.pend_done_next) begin
                    n_state = i_status.last ? S_FINIT : S_IDLE;
                end
            end
            S_RMUL: begin
                o_cmd.op = xxh_pkg::DP_RMUL;
                n_state  = S_RADD;
            end
            S_RADD: begin
                o_cmd.op = xxh_pkg::DP_RADD;
                n_state  = S_RMUL2;
            end
            S_RMUL2: begin
                o_cmd.op = xxh_pkg::DP_RMUL2;
                n_lane   = r_lane + 2'd1;
                n_state  = (r_lane == 2'd3) ? S_WRITE : S_RMUL;
            end
            S_FINIT: begin
                o_cmd.op = xxh_pkg::DP_FINIT;
                if (i_status.long_msg) begin
                    n_state = S_FLANE;
                    n_lane  = 2'd0;
                end else begin
                    n_state = tail_state(i_status.fill);
                end
            end
            S_FLANE: begin
                o_cmd.op = xxh_pkg::DP_FLANE;
                n_lane   = r_lane + 2'd1;
                if (r_lane == 2'd3) begin
                    n_state = tail_state(i_status.fill);
                end
            end
            S_WMUL: begin
                o_cmd.op = xxh_pkg::DP_WMUL;
                n_state  = S_WADD;
            end
            S_WADD: begin
                o_cmd.op = xxh_pkg::DP_WADD;
                n_state  = S_WMUL2;
            end
            S_WMUL2: begin
                o_cmd.op = xxh_pkg::DP_WMUL2;
                n_state  = tail_state(i_status.fill - 5'd4);
            end
            S_BMUL: begin
                o_cmd.op = xxh_pkg::DP_BMUL;
                n_state  = S_BADD;
            end
            S_BADD: begin
                o_cmd.op = xxh_pkg::DP_BADD;
                n_state  = S_BMUL2;
            end
            S_BMUL2: begin
                o_cmd.op = xxh_pkg::DP_BMUL2;
                n_state  = tail_state(i_status.fill - 5'd1);
            end
            S_AV1: begin
                o_cmd.op = xxh_pkg::DP_AV1;
                n_state  = S_AV2;
            end
            S_AV2: begin
                o_cmd.op = xxh_pkg::DP_AV2;
                n_state  = S_AV3;
            end
            S_AV3: begin
                // The digest waits here until the output register is free.
                if (w_out_free) begin
                    o_cmd.op    = xxh_pkg::DP_AV3;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lane      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lane      <= n_lane;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/xxh_dp.sv */
// ----------------------------------------------------------------------------
// XXH32 stream hasher datapath
// Lanes, stripe buffer, length and fill counters, and one shared 32x32
// multiplier that serves rounds, tail folding and the avalanche.
// ----------------------------------------------------------------------------
module xxh_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  xxh_pkg::t_dp_cmd    i_cmd,
    output xxh_pkg::t_dp_status o_status,
    input  logic                i_cfg_valid,
    input  logic [31:0]         i_cfg_seed,
    input  logic [31:0]         i_data_bytes,
    input  logic [2:0]          i_byte_count,
    input  logic                i_last,
    output logic [31:0]         o_hash_value
);

    logic [31:0] r_seed;
    logic [31:0] r_acc [4];
    logic [7:0]  r_buf [16];
    logic [4:0]  r_fill;
    logic [31:0] r_len;
    logic        r_long;
    logic [31:0] r_pend_data;
    logic [2:0]  r_pend_cnt;
    logic        r_last;
    logic [31:0] r_prod;
    logic [31:0] r_h;
    logic [31:0] r_hash;

    logic [4:0]  w_room;
    logic [2:0]  w_n;
    logic [31:0] w_word0;
    logic [31:0] w_mul_a, w_mul_b, w_mul;
    logic [31:0] w_seed_src;
    logic [4:0]  w_fin_rot;
    logic        w_cfg_reseed;
    logic [4:0]  w_off   [16];
    logic        w_wr_en [16];
    logic [7:0]  w_wr_byte [16];

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] r);
        return (v << r) | (v >> (6'd32 - {1'b0, r}));
    endfunction

    // Bytes that fit before the stripe boundary go in this write.
    assign w_room  = 5'd16 - r_fill;
    assign w_n     = ({2'b00, r_pend_cnt} < w_room) ? r_pend_cnt : w_room[2:0];
    assign w_word0 = {r_buf[3], r_buf[2], r_buf[1], r_buf[0]};

    assign w_seed_src   = i_cfg_valid ? i_cfg_seed : r_seed;
    assign w_cfg_reseed = i_cfg_valid && (r_len == 32'd0) && !r_long && (r_fill == 5'd0);

    always_comb begin
        for (int p = 0; p < 16; p++) begin
            w_off[p]     = 5'(p) - r_fill;
            w_wr_en[p]   = (5'(p) >= r_fill) && (w_off[p] < {2'b00, w_n});
            w_wr_byte[p] = r_pend_data[{w_off[p][1:0], 3'b000} +: 8];
        end
    end

    always_comb begin
        case (i_cmd.lane)
            2'd0:    w_fin_rot = 5'd1;
            2'd1:    w_fin_rot = 5'd7;
            2'd2:    w_fin_rot = 5'd12;
            default: w_fin_rot = 5'd18;
        endcase
    end

    always_comb begin
        case (i_cmd.op)
            xxh_pkg::DP_RMUL: begin
                w_mul_a = w_word0;
                w_mul_b = xxh_pkg::PRIME2;
            end
            xxh_pkg::DP_RMUL2: begin
                w_mul_a = r_prod;
                w_mul_b = xxh_pkg::PRIME1;
            end
            xxh_pkg::DP_WMUL: begin
                w_mul_a = w_word0;
                w_mul_b = xxh_pkg::PRIME3;
            end
            xxh_pkg::DP_WMUL2: begin
                w_mul_a = r_h;
                w_mul_b = xxh_pkg::PRIME4;
            end
            xxh_pkg::DP_BMUL: begin
                w_mul_a = {24'd0, r_buf[0]};
                w_mul_b = xxh_pkg::PRIME5;
            end
            xxh_pkg::DP_BMUL2: begin
                w_mul_a = r_h;
                w_mul_b = xxh_pkg::PRIME1;
            end
            xxh_pkg::DP_AV1: begin
                w_mul_a = r_h ^ (r_h >> 15);
                w_mul_b = xxh_pkg::PRIME2;
            end
            xxh_pkg::DP_AV2: begin
                w_mul_a = r_h ^ (r_h >> 13);
                w_mul_b = xxh_pkg::PRIME3;
            end
            default: begin
                w_mul_a = 32'd0;
                w_mul_b = 32'd0;
            end
        endcase
    end

    assign w_mul = w_mul_a * w_mul_b;

    // Lanes, counters and seed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= 32'd0;
            r_acc[0] <= xxh_pkg::PRIME1 + xxh_pkg::PRIME2;
            r_acc[1] <= xxh_pkg::PRIME2;
            r_acc[2] <= 32'd0;
            r_acc[3] <= 32'd0 - xxh_pkg::PRIME1;
            r_fill   <= 5'd0;
            r_len    <= 32'd0;
            r_long   <= 1'b0;
        end else begin
            case (i_cmd.op)
                xxh_pkg::DP_WRITE: begin
                    r_fill <= r_fill + {2'b00, w_n};
                    r_len  <= r_len + {29'd0, w_n};
                end
                xxh_pkg::DP_RMUL2: begin
                    r_acc[0] <= r_acc[1];
                    r_acc[1] <= r_acc[2];
                    r_acc[2] <= r_acc[3];
                    r_acc[3] <= w_mul;
                    if (i_cmd.lane == 2'd3) begin
                        r_fill <= 5'd0;
                        r_long <= 1'b1;
                    end
                end
                xxh_pkg::DP_FLANE: begin
                    r_acc[0] <= r_acc[1];
                    r_acc[1] <= r_acc[2];
                    r_acc[2] <= r_acc[3];
                    r_acc[3] <= r_acc[0];
                end
                xxh_pkg::DP_WMUL2: begin
                    r_fill <= r_fill - 5'd4;
                end
                xxh_pkg::DP_BMUL2: begin
                    r_fill <= r_fill - 5'd1;
                end
                xxh_pkg::DP_AV3: begin
                    r_fill <= 5'd0;
                    r_len  <= 32'd0;
                    r_long <= 1'b0;
                end
                default: begin
                end
            endcase
            if (i_cfg_valid) begin
                r_seed <= i_cfg_seed;
            end
            // Re-seed after a digest, or on a seed write before any byte arrived.
            if (w_cfg_reseed || (i_cmd.op == xxh_pkg::DP_AV3)) begin
                r_acc[0] <= w_seed_src + xxh_pkg::PRIME1 + xxh_pkg::PRIME2;
                r_acc[1] <= w_seed_src + xxh_pkg::PRIME2;
                r_acc[2] <= w_seed_src;
                r_acc[3] <= w_seed_src - xxh_pkg::PRIME1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            xxh_pkg::DP_LOAD: begin
                r_pend_data <= i_data_bytes;
                r_pend_cnt  <= (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;
                r_last      <= i_last;
            end
            xxh_pkg::DP_WRITE: begin
                for (int p = 0; p < 16; p++) begin
                    if (w_wr_en[p]) begin
                        r_buf[p] <= w_wr_byte[p];
                    end
                end
                r_pend_data <= r_pend_data >> {w_n, 3'b000};
                r_pend_cnt  <= r_pend_cnt - w_n;
            end
            xxh_pkg::DP_RMUL: begin
                r_prod <= w_mul;
            end
            xxh_pkg::DP_RADD: begin
                r_prod <= rotl(r_acc[0] + r_prod, 5'd13);
            end
            xxh_pkg::DP_RMUL2: begin
                for (int p = 0; p < 12; p++) begin
                    r_buf[p] <= r_buf[p + 4];
                end
            end
            xxh_pkg::DP_FINIT: begin
                r_h <= r_long ? r_len : (r_len + r_acc[2] + xxh_pkg::PRIME5);
            end
            xxh_pkg::DP_FLANE: begin
                r_h <= r_h + rotl(r_acc[0], w_fin_rot);
            end
            xxh_pkg::DP_WMUL: begin
                r_prod <= w_mul;
            end
            xxh_pkg::DP_WADD: begin
                r_h <= rotl(r_h + r_prod, 5'd17);
            end
            xxh_pkg::DP_WMUL2: begin
                r_h <= w_mul;
                for (int p = 0; p < 12; p++) begin
                    r_buf[p] <= r_buf[p + 4];
                end
            end
            xxh_pkg::DP_BMUL: begin
                r_prod <= w_mul;
            end
            xxh_pkg::DP_BADD: begin
                r_h <= rotl(r_h + r_prod, 5'd11);
            end
            xxh_pkg::DP_BMUL2: begin
                r_h <= w_mul;
                for (int p = 0; p < 15; p++) begin
                    r_buf[p] <= r_buf[p + 1];
                end
            end
            xxh_pkg::DP_AV1: begin
                r_h <= w_mul;
            end
            xxh_pkg::DP_AV2: begin
                r_h <= w_mul;
            end
            xxh_pkg::DP_AV3: begin
                r_hash <= r_h ^ (r_h >> 16);
            end
            default: begin
            end
        endcase
    end

    assign o_status.fill             = r_fill;
    assign o_status.stripe_full_next = ((r_fill + {2'b00, w_n}) == 5'd16);
    assign o_status.pend_done_next   = (r_pend_cnt == w_n);
    assign o_status.last             = r_last;
    assign o_status.long_msg         = r_long;
    assign o_hash_value              = r_hash;

endmodule

/* rtl/xxh32_stream_hasher.sv */
// ----------------------------------------------------------------------------
// XXH32 stream hasher top level
// Streaming 32-bit xxHash over items of up to four little-endian bytes.
// ----------------------------------------------------------------------------
// Items are taken one at a time. An item that does not complete a 16-byte
// stripe is accepted and given one byte write. Completing a stripe adds a
// round: each of the four lanes makes three steps through the single shared
// 32x32 multiplier (multiply, add and rotate, multiply), and one more byte
// write takes whatever bytes are left. A last item adds the finish: a fold
// of the four lanes when the message reached 16 bytes, a fold per leftover
// 4-byte word and per leftover byte, and the avalanche; it waits in its final
// step until the previous hash has been taken. The output register holds a
// finished hash while the next message streams in. The seed register may be
// written while idle; it re-seeds the lanes at once when no byte of the
// current message has arrived, and otherwise from the next message.
module xxh32_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_data_bytes,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_hash_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_seed
);

    xxh_pkg::t_dp_cmd    w_cmd;
    xxh_pkg::t_dp_status w_status;

    // The seed register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;

    xxh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    xxh_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_seed   (i_cfg_seed),
        .i_data_bytes (i_data_bytes),
        .i_byte_count (i_byte_count),
        .i_last       (i_last),
        .o_hash_value (o_hash_value)
    );

endmodule

/* rtl/xxh_checker.sv */
// ----------------------------------------------------------------------------
// XXH32 stream hasher port checker
// Timing properties seen on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "xxh32_stream_hasher_macros.svh"

module xxh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [2:0]  i_byte_count,
    input logic        i_last,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_hash_value
);

    logic w_in_xfer;
    logic w_out_stall;
    logic w_empty_xfer;

    assign w_in_xfer    = i_in_valid && o_in_ready;
    assign w_out_stall  = o_out_valid && !i_out_ready;
    assign w_empty_xfer = w_in_xfer && (i_byte_count == 3'd0) && !i_last;

    // A stalled hash must stay on the port unchanged.
    `XXH_ASSERT_NEXT(a_hash_hold, w_out_stall, o_out_valid && $stable(o_hash_value), "hash moved")

    // Every input transfer keeps the block busy for at least its byte write.
    `XXH_ASSERT_NEXT(a_busy_after_transfer, w_in_xfer, !o_in_ready, "ready stayed high")

    // A new hash only appears at the end of processing, never while idle.
    `XXH_ASSERT_SAME(a_hash_from_busy, $rose(o_out_valid), $past(!o_in_ready), "hash while idle")

    // An empty item that does not end the message returns to idle right after its byte write.
    `XXH_ASSERT_NEXT2(a_empty_item_quick, w_empty_xfer, o_in_ready, "empty item stayed busy")

endmodule

bind xxh32_stream_hasher xxh_checker u_xxh_checker (.*);
